// File: hw/rtl/sirt_pkg.sv
// Package with the shared types, constants and alphabet functions of the radix text converter.
`timescale 1ns / 1ps

package sirt_pkg;

    // Configuration register file layout.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_LEN   = 16;
    localparam int ALPHA_IDX_W = 4;

    // Bits of the quotient handled by the divider in one cycle.
    localparam int STEP_BITS = 8;

    // Characters that may never appear in the alphabet.
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CTRL_LO    = 8'd9;
    localparam logic [CHAR_W-1:0] CTRL_HI    = 8'd13;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIGIT_LOW  = 2'd0,
        REG_DIGIT_HIGH = 2'd1,
        REG_BASE_SIZE  = 2'd2
    } t_cfg_reg;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_SIGN   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_SHOW   = 6'b100000
    } t_state;

    // Command from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic load;
    } t_div_cmd;

    // Status from the divider back to the sequencer.
    typedef struct packed {
        logic done;
        logic quo_zero;
    } t_div_stat;

    // Picks alphabet character k out of the two configuration words.
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CFG_DATA_W-1:0]  lo,
        input logic [CFG_DATA_W-1:0]  hi,
        input logic [ALPHA_IDX_W-1:0] k
    );
        logic [2*CFG_DATA_W-1:0] both;
        both = {hi, lo};
        return both[k*CHAR_W +: CHAR_W];
    endfunction

    // True when the first n characters form a usable alphabet.
    function automatic logic alphabet_ok(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [BASE_W-1:0]     n,
        input logic [BASE_W-1:0]     max_n
    );
        logic              ok;
        logic [CHAR_W-1:0] ca;
        ok = (n >= BASE_W'(2)) && (n <= max_n) && (n <= BASE_W'(ALPHA_LEN));
        for (int a = 0; a < ALPHA_LEN; a++) begin
            ca = alpha_char(lo, hi, ALPHA_IDX_W'(a));
            if (BASE_W'(a) < n) begin
                if (ca == CHAR_PLUS || ca == CHAR_MINUS || ca == CHAR_SPACE ||
                    ca == CHAR_NUL || (ca >= CTRL_LO && ca <= CTRL_HI)) begin
                    ok = 1'b0;
                end
                for (int b = a + 1; b < ALPHA_LEN; b++) begin
                    if (BASE_W'(b) < n && alpha_char(lo, hi, ALPHA_IDX_W'(b)) == ca) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

// File: hw/rtl/sirt_if.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface sirt_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirt_out_if;
    logic                           valid;
    logic                           ready;
    logic [sirt_pkg::CHAR_W-1:0]    text_char;
    logic                           status;
    logic                           last;

    modport source (output valid, output text_char, output status, output last, input ready);
    modport sink   (input valid, input text_char, input status, input last, output ready);
endinterface

interface sirt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sirt_pkg::CFG_IDX_W-1:0]   index;
    logic [sirt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/sirt_divider.sv
// Iterative divider: divides the held quotient by the radix, eight bits per cycle.
`timescale 1ns / 1ps

module sirt_divider #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16,
    localparam int RW        = $clog2(MAX_RADIX)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sirt_pkg::t_div_cmd   i_cmd,
    input  logic [VALUE_BITS-1:0] i_operand,
    input  logic [RW:0]          i_radix,
    output sirt_pkg::t_div_stat  o_stat,
    output logic [RW-1:0]        o_digit
);

    localparam int STEP   = sirt_pkg::STEP_BITS;
    localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
    localparam int QW     = CHUNKS * STEP;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [QW-1:0]   r_quo;
    logic [QW-1:0]   n_quo;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   n_rem;
    logic [CW-1:0]   r_chunk;
    logic            r_busy;
    logic            r_done;
    logic [RW:0]     partial;
    logic [RW-1:0]   rem;
    logic [STEP-1:0] qbits;

    // One chunk of restoring long division; the quotient bits shift in at the bottom.
    always_comb begin
        rem     = r_rem;
        qbits   = '0;
        partial = '0;
        for (int i = 0; i < STEP; i++) begin
            partial = {rem, r_quo[QW-1-i]};
            if (partial >= i_radix) begin
                qbits[STEP-1-i] = 1'b1;
                rem             = RW'(partial - i_radix);
            end else begin
                rem = partial[RW-1:0];
            end
        end
        n_rem = rem;
        n_quo = (r_quo << STEP) | QW'(qbits);
    end

    // Chunk counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_chunk <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_chunk <= '0;
            end else if (r_busy) begin
                r_chunk <= r_chunk + 1'b1;
                if (r_chunk == CW'(CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder; a start without load divides the last quotient again.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            if (i_cmd.load) begin
                r_quo <= QW'(i_operand);
            end
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quo_zero = (r_quo == '0);
    assign o_digit         = r_rem;

endmodule

// File: hw/rtl/signed_int_to_radix_text.sv
// Top level: converts a signed value into radix text using a configured alphabet.
// Steps: accept the value, check the alphabet, then one pass of the shared divider per digit,
// then the sign and the digits as characters, each held until the receiver takes it.
// A bad alphabet gives its single result straight from the check, without a divide.
// One conversion at a time; the next transaction is taken after the last character leaves.
// Synchronous active-low reset returns the control state to idle and clears all configuration registers to zero.
`timescale 1ns / 1ps

module signed_int_to_radix_text #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_RADIX  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sirt_in_if.sink      i_in,
    sirt_out_if.source   o_out,
    sirt_cfg_if.sink     i_cfg
);

    localparam int RW   = $clog2(MAX_RADIX);
    localparam int AW   = $clog2(VALUE_BITS);
    localparam int CNTW = $clog2(VALUE_BITS + 1);

    sirt_pkg::t_state    r_state;
    sirt_pkg::t_state    n_state;
    sirt_pkg::t_div_cmd  div_cmd;
    sirt_pkg::t_div_stat div_stat;

    logic [sirt_pkg::CFG_DATA_W-1:0] r_digit_low;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_digit_high;
    logic [sirt_pkg::BASE_W-1:0]     r_base_size;

    logic [VALUE_BITS-1:0]       in_value;
    logic [VALUE_BITS-1:0]       r_mag;
    logic [VALUE_BITS-1:0]       n_mag;
    logic                        r_neg;
    logic                        n_neg;
    logic [CNTW-1:0]             r_cnt;
    logic [CNTW-1:0]             n_cnt;
    logic [CNTW-1:0]             cnt_dec;
    logic [sirt_pkg::CHAR_W-1:0] r_out_char;
    logic [sirt_pkg::CHAR_W-1:0] n_out_char;
    logic                        r_out_status;
    logic                        n_out_status;
    logic                        r_out_last;
    logic                        n_out_last;
    logic                        r_out_digit;
    logic                        n_out_digit;
    logic                        alpha_ok;
    logic                        in_fire;
    logic                        out_fire;
    logic                        mem_we;
    logic                        rd_en;
    logic [RW-1:0]               digit;
    logic [RW-1:0]               r_rd_data;
    logic [RW-1:0]               r_digit_mem [VALUE_BITS];

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign in_value = i_in.value;
    assign cnt_dec  = r_cnt - 1'b1;
    assign alpha_ok = sirt_pkg::alphabet_ok(r_digit_low, r_digit_high, r_base_size,
                                            sirt_pkg::BASE_W'(MAX_RADIX));

    // Configuration registers; writes to unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_low  <= '0;
            r_digit_high <= '0;
            r_base_size  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                sirt_pkg::REG_DIGIT_LOW:  r_digit_low  <= i_cfg.data;
                sirt_pkg::REG_DIGIT_HIGH: r_digit_high <= i_cfg.data;
                sirt_pkg::REG_BASE_SIZE:  r_base_size  <= i_cfg.data[sirt_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared divider that produces one digit per pass.
    sirt_divider #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (div_cmd),
        .i_operand (r_mag),
        .i_radix   ((RW + 1)'(r_base_size)),
        .o_stat    (div_stat),
        .o_digit   (digit)
    );

    // Sequencer: check, divide repeatedly, then emit any sign and the digits from the top, or one bad result.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_out_char   = r_out_char;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_digit  = r_out_digit;
        div_cmd      = '0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        unique case (r_state)
            sirt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_neg   = in_value[VALUE_BITS-1];
                    n_mag   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
                    n_state = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK: begin
                if (alpha_ok) begin
                    div_cmd.start = 1'b1;
                    div_cmd.load  = 1'b1;
                    n_cnt         = '0;
                    n_state       = sirt_pkg::ST_DIVIDE;
                end else begin
                    n_out_char   = sirt_pkg::CHAR_NUL;
                    n_out_status = sirt_pkg::STATUS_BAD;
                    n_out_last   = 1'b1;
                    n_out_digit  = 1'b0;
                    n_state      = sirt_pkg::ST_SHOW;
                end
            end
            sirt_pkg::ST_DIVIDE: begin
                if (div_stat.done) begin
                    mem_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    if (div_stat.quo_zero || r_cnt == CNTW'(VALUE_BITS - 1)) begin
                        n_state = r_neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_READ;
                    end else begin
                        div_cmd.start = 1'b1;
                        div_cmd.load  = 1'b0;
                    end
                end
            end
            sirt_pkg::ST_SIGN: begin
                n_out_char   = sirt_pkg::CHAR_MINUS;
                n_out_status = sirt_pkg::STATUS_OK;
                n_out_last   = 1'b0;
                n_out_digit  = 1'b0;
                n_state      = sirt_pkg::ST_SHOW;
            end
            sirt_pkg::ST_READ: begin
                rd_en        = 1'b1;
                n_cnt        = cnt_dec;
                n_out_status = sirt_pkg::STATUS_OK;
                n_out_last   = (r_cnt == CNTW'(1));
                n_out_digit  = 1'b1;
                n_state      = sirt_pkg::ST_SHOW;
            end
            sirt_pkg::ST_SHOW: begin
                if (out_fire) begin
                    n_state = r_out_last ? sirt_pkg::ST_IDLE : sirt_pkg::ST_READ;
                end
            end
            default: n_state = sirt_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sirt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_last  <= 1'b0;
            r_out_digit <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_last  <= n_out_last;
            r_out_digit <= n_out_digit;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_mag        <= n_mag;
        r_out_char   <= n_out_char;
        r_out_status <= n_out_status;
    end

    // Digit store, least significant digit at address zero.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_digit_mem[r_cnt[AW-1:0]] <= digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_digit_mem[cnt_dec[AW-1:0]];
        end
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == sirt_pkg::ST_IDLE);
    assign o_out.valid     = (r_state == sirt_pkg::ST_SHOW);
    assign o_out.status    = r_out_status;
    assign o_out.last      = r_out_last;
    assign o_out.text_char = r_out_digit
        ? sirt_pkg::alpha_char(r_digit_low, r_digit_high, sirt_pkg::ALPHA_IDX_W'(r_rd_data))
        : r_out_char;

    // A digit is only stored while there is room for it.
    a_digit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sirt_pkg::ST_DIVIDE && div_stat.done) |-> (r_cnt < CNTW'(VALUE_BITS)))
        else $error("digit store overflow");

    // Reading always targets a digit that this conversion wrote.
    a_read_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sirt_pkg::ST_READ) |-> (r_cnt != '0))
        else $error("digit read with empty count");

    // A bad alphabet result is always the final result.
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> o_out.last)
        else $error("invalid result not marked last");

    // The final transaction returns the block to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (r_state == sirt_pkg::ST_IDLE))
        else $error("block not idle after last result");

    // The divider finishes only while the sequencer waits for it.
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == sirt_pkg::ST_DIVIDE))
        else $error("divider done outside divide state");

endmodule

// File: dv/signed_int_to_radix_text_tb.sv
// Testbench for the signed integer to radix text converter with a self-checking predictor.
`timescale 1ns / 1ps

module signed_int_to_radix_text_tb;

    localparam int VALUE_W       = 32;
    localparam int RADIX_LIMIT   = 16;
    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 20;

    // Register index that the block does not decode.
    localparam logic [sirt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Decimal and upper-case hexadecimal alphabets.
    localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
    localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;

    // Sixteen legal bytes, many of them next to the banned ones or with the top bit set.
    localparam logic [63:0] EDGE_LO = 64'hFF80_7F0E_0801_2A2C;
    localparam logic [63:0] EDGE_HI = 64'h2E1F_21FE_C35A_A53C;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [sirt_pkg::CHAR_W-1:0] text_char;
        logic                        status;
        logic                        last;
    } t_text_result;

    logic i_clk;
    logic i_rst_n;

    sirt_in_if #(.VALUE_BITS(VALUE_W)) in_if ();
    sirt_out_if                        out_if ();
    sirt_cfg_if                        cfg_if ();

    signed_int_to_radix_text #(
        .VALUE_BITS(VALUE_W),
        .MAX_RADIX (RADIX_LIMIT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // Alphabet registers as the predictor sees them.
    logic [63:0]                 alpha_lo;
    logic [63:0]                 alpha_hi;
    logic [sirt_pkg::BASE_W-1:0] alpha_size;

    logic [VALUE_W-1:0] pending_values [$];
    t_text_result       expected_text [$];

    int   fault_count;
    int   cycle_count;
    int   gap_left;
    int   stall_left;
    int   hold_left;
    logic hold_arm;
    logic idle_on;

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Returns digit character k of the current alphabet.
    function automatic logic [sirt_pkg::CHAR_W-1:0] digit_char(input int k);
        if (k < 8) begin
            return alpha_lo[8*k +: 8];
        end
        return alpha_hi[8*(k-8) +: 8];
    endfunction

    // A character is usable unless it is a sign, white space or NUL.
    function automatic bit char_allowed(input logic [sirt_pkg::CHAR_W-1:0] c);
        return !(c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS ||
                 c == sirt_pkg::CHAR_SPACE || c == sirt_pkg::CHAR_NUL ||
                 (c >= sirt_pkg::CTRL_LO && c <= sirt_pkg::CTRL_HI));
    endfunction

    // One of the nine bytes that an alphabet must not hold.
    function automatic logic [sirt_pkg::CHAR_W-1:0] banned_char(input int k);
        case (k)
            0: return sirt_pkg::CHAR_PLUS;
            1: return sirt_pkg::CHAR_MINUS;
            2: return sirt_pkg::CHAR_SPACE;
            3: return sirt_pkg::CHAR_NUL;
            default: return sirt_pkg::CTRL_LO + sirt_pkg::CHAR_W'(k - 4);
        endcase
    endfunction

    // The alphabet must have 2 to 16 distinct usable characters.
    function automatic bit alphabet_usable();
        if (alpha_size < 2 || alpha_size > RADIX_LIMIT) begin
            return 1'b0;
        end
        for (int a = 0; a < int'(alpha_size); a++) begin
            if (!char_allowed(digit_char(a))) begin
                return 1'b0;
            end
            for (int b = a + 1; b < int'(alpha_size); b++) begin
                if (digit_char(b) == digit_char(a)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Predicts the characters of one conversion and queues them.
    function automatic void convert_to_text(input logic [VALUE_W-1:0] raw);
        logic               negative;
        logic [VALUE_W-1:0] quotient;
        logic [VALUE_W-1:0] radix;
        logic [3:0]         digit_idx [VALUE_W];
        int                 n_digits;
        negative = raw[VALUE_W-1];
        quotient = negative ? (VALUE_W'(0) - raw) : raw;
        if (!alphabet_usable()) begin
            expected_text.push_back('{sirt_pkg::CHAR_NUL, sirt_pkg::STATUS_BAD, 1'b1});
            return;
        end
        radix    = VALUE_W'(alpha_size);
        n_digits = 0;
        // Digits come out least significant first.
        do begin
            digit_idx[n_digits] = 4'(quotient % radix);
            quotient = quotient / radix;
            n_digits++;
        end while (quotient != 0 && n_digits < VALUE_W);
        if (negative) begin
            expected_text.push_back('{sirt_pkg::CHAR_MINUS, sirt_pkg::STATUS_OK, 1'b0});
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            expected_text.push_back('{digit_char(int'(digit_idx[k])), sirt_pkg::STATUS_OK,
                                      k == 0});
        end
    endfunction

    // Random value: full range, small magnitudes, extremes or reduced widths.
    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5: return VALUE_W'($urandom_range(0, 600)) - VALUE_W'(300);
            6: begin
                case ($urandom_range(0, 4))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    3: return '1;
                    default: return VALUE_W'(1);
                endcase
            end
            default: return VALUE_W'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
    endfunction

    // Builds a random alphabet, either usable or broken in one way.
    task automatic make_alphabet(input bit usable, output logic [63:0] lo,
                                 output logic [63:0] hi, output logic [63:0] base_word);
        logic [127:0]                chars;
        logic [sirt_pkg::CHAR_W-1:0] c;
        bit                          clash;
        int                          size;
        int                          a;
        int                          b;
        case ($urandom_range(0, 9))
            0, 1, 2: size = 16;
            3, 4: size = 2;
            default: size = $urandom_range(2, 16);
        endcase
        // Unused bytes stay random and may hold anything.
        chars = {$urandom, $urandom, $urandom, $urandom};
        for (int k = 0; k < size; k++) begin
            do begin
                c     = sirt_pkg::CHAR_W'($urandom);
                clash = !char_allowed(c);
                for (int j = 0; j < k; j++) begin
                    if (chars[8*j +: 8] == c) begin
                        clash = 1'b1;
                    end
                end
            end while (clash);
            chars[8*k +: 8] = c;
        end
        if (!usable) begin
            case ($urandom_range(0, 3))
                0: size = $urandom_range(0, 1);
                1: size = $urandom_range(17, 31);
                2: begin
                    a = $urandom_range(0, size - 2);
                    b = $urandom_range(a + 1, size - 1);
                    chars[8*b +: 8] = chars[8*a +: 8];
                end
                default: begin
                    chars[8*$urandom_range(0, size - 1) +: 8] = banned_char($urandom_range(0, 8));
                end
            endcase
        end
        lo = chars[63:0];
        hi = chars[127:64];
        // Only the low five bits of the size register count.
        base_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        base_word[sirt_pkg::BASE_W-1:0] = sirt_pkg::BASE_W'(size);
    endtask

    // Writes all alphabet registers, keeping valid high between transactions.
    task automatic load_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [63:0] base_word, input bit poke_spare);
        logic [sirt_pkg::CFG_IDX_W-1:0] reg_idx  [4];
        logic [63:0]                    reg_data [4];
        int                             n_writes;
        reg_idx[0]  = sirt_pkg::REG_DIGIT_LOW;
        reg_data[0] = lo;
        reg_idx[1]  = sirt_pkg::REG_DIGIT_HIGH;
        reg_data[1] = hi;
        reg_idx[2]  = sirt_pkg::REG_BASE_SIZE;
        reg_data[2] = base_word;
        n_writes    = 3;
        if (poke_spare) begin
            reg_idx[3]  = REG_SPARE;
            reg_data[3] = {$urandom, $urandom};
            n_writes    = 4;
        end
        for (int w = 0; w < n_writes; w++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_idx[w];
            cfg_if.data  <= reg_data[w];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (reg_idx[w])
                sirt_pkg::REG_DIGIT_LOW:  alpha_lo   = reg_data[w];
                sirt_pkg::REG_DIGIT_HIGH: alpha_hi   = reg_data[w];
                sirt_pkg::REG_BASE_SIZE:  alpha_size = reg_data[w][sirt_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every queued value is taken and every character has arrived.
    task automatic drain();
        while (pending_values.size() != 0 || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Input driver: offers queued values and predicts each accepted one.
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                convert_to_text(in_if.value);
                pending_values.delete(0);
                took = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 5);
                end
            end
            if (in_if.valid && !took) begin
                // Hold the offered value until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
                in_if.valid <= 1'b1;
                in_if.value <= pending_values[0];
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off that lets the block back up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
            hold_arm  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compares each accepted character with the oldest prediction.
    always @(posedge i_clk) begin
        t_text_result got;
        t_text_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.text_char, out_if.status, out_if.last};
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected result char=%h status=%b last=%b",
                             $time, got.text_char, got.status, got.last);
                    fault_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (got.text_char !== want.text_char) begin
                        $display("%0t: text_char mismatch expected=%h actual=%h",
                                 $time, want.text_char, got.text_char);
                        fault_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch expected=%b actual=%b",
                                 $time, want.status, got.status);
                        fault_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last mismatch expected=%b actual=%b",
                                 $time, want.last, got.last);
                        fault_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                stall_left = $urandom_range(1, 5);
            end
            out_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed alphabets and values, then random phases.
    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] base_word;
        int          n_items;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        hold_arm     = 1'b0;
        idle_on      = 1'b1;
        fault_count  = 0;
        cycle_count  = 0;
        alpha_lo     = '0;
        alpha_hi     = '0;
        alpha_size   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset alphabet is empty, so the conversion is refused.
        pending_values.push_back(VALUE_W'(5));
        drain();

        // Decimal digits with zero, unit steps and both extremes.
        load_alphabet(DEC_LO, DEC_HI, 64'd10, 1'b0);
        pending_values.push_back('0);
        pending_values.push_back(VALUE_W'(1));
        pending_values.push_back('1);
        pending_values.push_back(VALUE_MAX);
        pending_values.push_back(VALUE_MIN);
        pending_values.push_back(-VALUE_W'(10));
        drain();

        // Junk above the five size bits leaves a radix of ten.
        load_alphabet(DEC_LO, DEC_HI, 64'hFFFF_FFFF_FFFF_FFEA, 1'b1);
        pending_values.push_back(-VALUE_W'(305));
        drain();

        // Binary, with banned bytes past the end of the alphabet.
        load_alphabet(64'h2D2B_200D_0900_3130, 64'h2B2D_2020_0909_0D0D, 64'd2, 1'b0);
        pending_values.push_back(VALUE_MIN);
        pending_values.push_back(VALUE_MAX);
        pending_values.push_back('1);
        drain();

        // Sixteen characters at the edges of the banned ranges.
        load_alphabet(EDGE_LO, EDGE_HI, 64'd16, 1'b0);
        pending_values.push_back(VALUE_MIN);
        pending_values.push_back(VALUE_MAX);
        pending_values.push_back(32'h1234_5678);
        drain();

        // Each banned byte inside an otherwise decimal alphabet.
        for (int k = 0; k < 9; k++) begin
            lo = DEC_LO;
            lo[8*(k % 8) +: 8] = banned_char(k);
            load_alphabet(lo, DEC_HI, 64'd10, 1'b0);
            pending_values.push_back(VALUE_W'(77));
            drain();
        end

        // A repeated digit, a single digit and a radix above sixteen.
        load_alphabet(64'h3736_3534_3332_3131, DEC_HI, 64'd10, 1'b0);
        pending_values.push_back(VALUE_W'(12));
        drain();
        load_alphabet(DEC_LO, HEX_HI, 64'd1, 1'b0);
        pending_values.push_back(VALUE_W'(3));
        drain();
        load_alphabet(DEC_LO, HEX_HI, 64'd17, 1'b0);
        pending_values.push_back(-VALUE_W'(3));
        drain();

        // Random alphabets with random values; every fifth alphabet is broken.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on <= !(p >= RANDOM_PHASES - 3 || p == 9);
            make_alphabet(p % 5 != 4, lo, hi, base_word);
            n_items = (p % 5 == 4) ? 5 : 22;
            load_alphabet(lo, hi, base_word, $urandom_range(0, 3) == 0);
            if (p == 2) begin
                hold_arm <= 1'b1;
            end
            for (int i = 0; i < n_items; i++) begin
                pending_values.push_back(random_value());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
